FILE: src/wdcm_pkg.sv
// Package for the wind direction circular mean block.
// Holds shared constants, state machine types and the CORDIC arctangent table.
// No dependencies.
`timescale 1ns / 1ps

package wdcm_pkg;

  // Defaults for the top-level parameters.
  localparam int WINDOW_DEF     = 20;
  localparam int ANGLE_BITS_DEF = 16;

  // Fixed widths of the channel payloads.
  localparam int IN_ANGLE_W  = 16;
  localparam int OUT_ANGLE_W = 16;
  localparam int OUT_COUNT_W = 5;

  // Depth of the queue between the front end and the engine.
  localparam int QUEUE_DEPTH = 2;

  // CORDIC constants.
  localparam int ROT_STEPS     = 16;
  localparam int VEC_STEPS_MAX = 24;
  localparam int STEP_W        = 5;
  localparam int Z_W           = 34;
  localparam int CORDIC_START  = 5094007;
  localparam int Q15_MAX       = 32767;

  // Front end states.
  typedef enum logic {
    FR_IDLE,
    FR_PUSH
  } front_state_t;

  // Engine states.
  typedef enum logic [2:0] {
    EN_IDLE,
    EN_ROT,
    EN_SUM,
    EN_VINIT,
    EN_VEC,
    EN_DONE
  } engine_state_t;

  // atan(2^-i) in units of 2^-32 turn.
  function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] idx);
    logic [31:0] val;
    unique case (idx)
      5'd0:    val = 32'd536870912;
      5'd1:    val = 32'd316933406;
      5'd2:    val = 32'd167458907;
      5'd3:    val = 32'd85004756;
      5'd4:    val = 32'd42667331;
      5'd5:    val = 32'd21354465;
      5'd6:    val = 32'd10679838;
      5'd7:    val = 32'd5340245;
      5'd8:    val = 32'd2670163;
      5'd9:    val = 32'd1335087;
      5'd10:   val = 32'd667544;
      5'd11:   val = 32'd333772;
      5'd12:   val = 32'd166886;
      5'd13:   val = 32'd83443;
      5'd14:   val = 32'd41722;
      5'd15:   val = 32'd20861;
      5'd16:   val = 32'd10430;
      5'd17:   val = 32'd5215;
      5'd18:   val = 32'd2608;
      5'd19:   val = 32'd1304;
      5'd20:   val = 32'd652;
      5'd21:   val = 32'd326;
      5'd22:   val = 32'd163;
      5'd23:   val = 32'd81;
      default: val = 32'd0;
    endcase
    return val;
  endfunction

endpackage

FILE: src/wdcm_ifs.sv
// Channel interfaces for the wind direction circular mean block.
// Depends on wdcm_pkg for the payload widths.
`timescale 1ns / 1ps

// Input channel: one wind direction sample per transaction.
interface wdcm_in_if;
  logic                                valid;
  logic                                ready;
  logic [wdcm_pkg::IN_ANGLE_W-1:0]     wind_angle;

  modport source (output valid, output wind_angle, input ready);
  modport sink   (input valid, input wind_angle, output ready);
endinterface

// Result channel: one mean direction and fill count per transaction.
interface wdcm_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [wdcm_pkg::OUT_ANGLE_W-1:0] mean_angle;
  logic [wdcm_pkg::OUT_COUNT_W-1:0]    filled_count;

  modport source (output valid, output mean_angle, output filled_count, input ready);
  modport sink   (input valid, input mean_angle, input filled_count, output ready);
endinterface

FILE: src/wdcm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module wdcm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 20
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: src/wdcm_fifo.sv
// Small register queue that decouples the front end from the engine.
// No dependencies.
`timescale 1ns / 1ps

module wdcm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: src/wdcm_front.sv
// Front end: accepts samples, keeps the sample window and its fill count,
// and queues each sample with the one it evicts. Depends on wdcm_pkg and wdcm_ram.
`timescale 1ns / 1ps

module wdcm_front #(
  parameter int WINDOW     = wdcm_pkg::WINDOW_DEF,
  parameter int ANGLE_BITS = wdcm_pkg::ANGLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [wdcm_pkg::IN_ANGLE_W-1:0]       in_angle,
  output logic                                  push_valid,
  input  logic                                  push_ready,
  output logic [2*ANGLE_BITS+$clog2(WINDOW+1):0] push_data
);

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);

  wdcm_pkg::front_state_t state_r, state_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [ANGLE_BITS-1:0] angle_r, angle_nxt;
  logic [ANGLE_BITS-1:0] old_angle;
  logic                  old_valid;
  logic [CNT_W-1:0]      new_count;
  logic                  ram_we;

  // Sample window. The slot to be replaced is read continuously, so its
  // old value is ready in the cycle after a sample is accepted.
  wdcm_ram #(
    .WIDTH (ANGLE_BITS),
    .DEPTH (WINDOW)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (angle_r),
    .raddr (slot_r),
    .rdata (old_angle)
  );

  // The window fills in slot order, so the replaced slot holds a sample
  // exactly when the window is full.
  assign old_valid = (count_r == CNT_W'(WINDOW));
  assign new_count = old_valid ? count_r : count_r + 1'b1;
  assign push_data = {new_count, old_valid, old_angle, angle_r};

  // Next state and handshake control.
  always_comb begin
    state_nxt  = state_r;
    slot_nxt   = slot_r;
    count_nxt  = count_r;
    angle_nxt  = angle_r;
    in_ready   = 1'b0;
    push_valid = 1'b0;
    ram_we     = 1'b0;
    unique case (state_r)
      wdcm_pkg::FR_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          angle_nxt = ANGLE_BITS'(in_angle);
          state_nxt = wdcm_pkg::FR_PUSH;
        end
      end
      wdcm_pkg::FR_PUSH: begin
        push_valid = 1'b1;
        if (push_ready) begin
          ram_we    = 1'b1;
          slot_nxt  = (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + 1'b1;
          count_nxt = new_count;
          state_nxt = wdcm_pkg::FR_IDLE;
        end
      end
      default: begin
        state_nxt = wdcm_pkg::FR_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wdcm_pkg::FR_IDLE;
      slot_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
      count_r <= count_nxt;
    end
  end

  // Sample holding register needs no reset.
  always_ff @(posedge clk) begin
    angle_r <= angle_nxt;
  end

endmodule

FILE: src/wdcm_engine.sv
// Engine: two-lane rotation CORDIC for the cosine and sine of the new and the
// evicted sample, running sums, and a vectoring CORDIC for the mean direction.
// Depends on wdcm_pkg.
`timescale 1ns / 1ps

module wdcm_engine #(
  parameter int WINDOW     = wdcm_pkg::WINDOW_DEF,
  parameter int ANGLE_BITS = wdcm_pkg::ANGLE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   pop_valid,
  output logic                                   pop_ready,
  input  logic [2*ANGLE_BITS+$clog2(WINDOW+1):0] pop_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [wdcm_pkg::OUT_ANGLE_W-1:0] out_mean,
  output logic [wdcm_pkg::OUT_COUNT_W-1:0]       out_count
);

  localparam int CNT_W     = $clog2(WINDOW + 1);
  localparam int SUM_W     = 16 + $clog2(WINDOW);
  localparam int D_W       = SUM_W + 10;
  localparam int Z_W       = wdcm_pkg::Z_W;
  localparam int STEP_W    = wdcm_pkg::STEP_W;
  localparam int VEC_STEPS = (ANGLE_BITS > wdcm_pkg::VEC_STEPS_MAX) ?
                             wdcm_pkg::VEC_STEPS_MAX : ANGLE_BITS;
  localparam logic [31:0] ROUND_HALF = 32'd1 << (31 - ANGLE_BITS);

  wdcm_pkg::engine_state_t state_r, state_nxt;

  logic signed [D_W-1:0]   x0_r, x0_nxt, y0_r, y0_nxt, x1_r, x1_nxt, y1_r, y1_nxt;
  logic signed [Z_W-1:0]   z0_r, z0_nxt, z1_r, z1_nxt;
  logic                    flip0_r, flip0_nxt, flip1_r, flip1_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic                    old_valid_r, old_valid_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic signed [SUM_W-1:0] cos_sum_r, cos_sum_nxt, sin_sum_r, sin_sum_nxt;
  logic                    zero_r, zero_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [wdcm_pkg::OUT_ANGLE_W-1:0] out_mean_r, out_mean_nxt;
  logic [wdcm_pkg::OUT_COUNT_W-1:0]        out_count_r, out_count_nxt;

  logic signed [D_W-1:0]   sx0, sy0, sx1, sy1;
  logic signed [Z_W-1:0]   sz0, sz1, iz0, iz1;
  logic                    if0, if1, ccw0;
  logic signed [15:0]      c_old, s_old, c_new, s_new;
  logic signed [D_W-1:0]   vx, vy;
  logic [31:0]             z_round;
  logic [ANGLE_BITS-1:0]   mean_full;
  logic                    out_free;

  // One CORDIC micro-rotation. ccw turns the vector counterclockwise.
  function automatic void cordic_step(
    input  logic signed [D_W-1:0] xi,
    input  logic signed [D_W-1:0] yi,
    input  logic signed [Z_W-1:0] zi,
    input  logic [STEP_W-1:0]     idx,
    input  logic                  ccw,
    output logic signed [D_W-1:0] xo,
    output logic signed [D_W-1:0] yo,
    output logic signed [Z_W-1:0] zo
  );
    logic signed [D_W-1:0] dx, dy;
    logic signed [Z_W-1:0] at;
    dx = yi >>> idx;
    dy = xi >>> idx;
    at = signed'(Z_W'(wdcm_pkg::atan_turn(idx)));
    if (ccw) begin
      xo = xi - dx;
      yo = yi + dy;
      zo = zi - at;
    end else begin
      xo = xi + dx;
      yo = yi - dy;
      zo = zi + at;
    end
  endfunction

  // Maps a sample to a start angle within a quarter turn of zero.
  function automatic void rot_start(
    input  logic [ANGLE_BITS-1:0] angle,
    output logic signed [Z_W-1:0] zo,
    output logic                  flip
  );
    logic [31:0] ph;
    ph   = {angle, {(32 - ANGLE_BITS){1'b0}}};
    flip = ph[31] ^ ph[30];
    ph[31] = ph[31] ^ flip;
    zo   = Z_W'(signed'(ph));
  endfunction

  // Round to Q15 and saturate, negating first for angles that were folded.
  function automatic logic signed [15:0] to_q15(
    input logic signed [D_W-1:0] v,
    input logic                  flip
  );
    logic signed [D_W-1:0] t;
    logic signed [D_W-1:0] r;
    logic signed [15:0]    q;
    t = (flip ? -v : v) + D_W'(128);
    r = t >>> 8;
    if (r > D_W'(wdcm_pkg::Q15_MAX)) begin
      q = 16'(wdcm_pkg::Q15_MAX);
    end else if (r < -D_W'(wdcm_pkg::Q15_MAX)) begin
      q = -16'(wdcm_pkg::Q15_MAX);
    end else begin
      q = 16'(r);
    end
    return q;
  endfunction

  assign out_free = !out_valid_r || out_ready;

  // Datapath terms used by several states.
  always_comb begin
    ccw0 = (state_r == wdcm_pkg::EN_VEC) ? y0_r[D_W-1] : ~z0_r[Z_W-1];
    cordic_step(x0_r, y0_r, z0_r, step_r, ccw0, sx0, sy0, sz0);
    cordic_step(x1_r, y1_r, z1_r, step_r, ~z1_r[Z_W-1], sx1, sy1, sz1);
    rot_start(pop_data[2*ANGLE_BITS-1:ANGLE_BITS], iz0, if0);
    rot_start(pop_data[ANGLE_BITS-1:0], iz1, if1);
    c_old = to_q15(x0_r, flip0_r);
    s_old = to_q15(y0_r, flip0_r);
    c_new = to_q15(x1_r, flip1_r);
    s_new = to_q15(y1_r, flip1_r);
    vx = D_W'(cos_sum_r) <<< 8;
    vy = D_W'(sin_sum_r) <<< 8;
    z_round   = z0_r[31:0] + ROUND_HALF;
    mean_full = z_round[31 -: ANGLE_BITS];
  end

  // Sequencer: next state and register updates.
  always_comb begin
    state_nxt     = state_r;
    x0_nxt        = x0_r;
    y0_nxt        = y0_r;
    z0_nxt        = z0_r;
    x1_nxt        = x1_r;
    y1_nxt        = y1_r;
    z1_nxt        = z1_r;
    flip0_nxt     = flip0_r;
    flip1_nxt     = flip1_r;
    step_nxt      = step_r;
    old_valid_nxt = old_valid_r;
    count_nxt     = count_r;
    cos_sum_nxt   = cos_sum_r;
    sin_sum_nxt   = sin_sum_r;
    zero_nxt      = zero_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_mean_nxt  = out_mean_r;
    out_count_nxt = out_count_r;
    pop_ready     = 1'b0;
    unique case (state_r)
      // Take the next queued transaction and load both rotation lanes.
      wdcm_pkg::EN_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          x0_nxt        = D_W'(wdcm_pkg::CORDIC_START);
          y0_nxt        = '0;
          z0_nxt        = iz0;
          flip0_nxt     = if0;
          x1_nxt        = D_W'(wdcm_pkg::CORDIC_START);
          y1_nxt        = '0;
          z1_nxt        = iz1;
          flip1_nxt     = if1;
          old_valid_nxt = pop_data[2*ANGLE_BITS];
          count_nxt     = pop_data[2*ANGLE_BITS+1 +: CNT_W];
          step_nxt      = '0;
          state_nxt     = wdcm_pkg::EN_ROT;
        end
      end
      // Lane 0 rotates by the evicted sample, lane 1 by the new one.
      wdcm_pkg::EN_ROT: begin
        x0_nxt   = sx0;
        y0_nxt   = sy0;
        z0_nxt   = sz0;
        x1_nxt   = sx1;
        y1_nxt   = sy1;
        z1_nxt   = sz1;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(wdcm_pkg::ROT_STEPS - 1)) begin
          state_nxt = wdcm_pkg::EN_SUM;
        end
      end
      // Add the new sample's vector and remove the evicted one, if there is one.
      wdcm_pkg::EN_SUM: begin
        if (old_valid_r) begin
          cos_sum_nxt = cos_sum_r + SUM_W'(c_new) - SUM_W'(c_old);
          sin_sum_nxt = sin_sum_r + SUM_W'(s_new) - SUM_W'(s_old);
        end else begin
          cos_sum_nxt = cos_sum_r + SUM_W'(c_new);
          sin_sum_nxt = sin_sum_r + SUM_W'(s_new);
        end
        state_nxt = wdcm_pkg::EN_VINIT;
      end
      // Load the summed vector into lane 0, folded into the right half plane.
      wdcm_pkg::EN_VINIT: begin
        zero_nxt = (cos_sum_r == '0) && (sin_sum_r == '0);
        if (vx[D_W-1]) begin
          x0_nxt = -vx;
          y0_nxt = -vy;
          z0_nxt = Z_W'(32'h8000_0000);
        end else begin
          x0_nxt = vx;
          y0_nxt = vy;
          z0_nxt = '0;
        end
        step_nxt  = '0;
        state_nxt = wdcm_pkg::EN_VEC;
      end
      // Vectoring: drive y to zero and accumulate the angle.
      wdcm_pkg::EN_VEC: begin
        x0_nxt   = sx0;
        y0_nxt   = sy0;
        z0_nxt   = sz0;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(VEC_STEPS - 1)) begin
          state_nxt = wdcm_pkg::EN_DONE;
        end
      end
      // Hand the result to the output register once it is free.
      wdcm_pkg::EN_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_mean_nxt  = zero_r ? '0 : signed'(wdcm_pkg::OUT_ANGLE_W'(mean_full));
          out_count_nxt = wdcm_pkg::OUT_COUNT_W'(count_r);
          state_nxt     = wdcm_pkg::EN_IDLE;
        end
      end
      default: begin
        state_nxt = wdcm_pkg::EN_IDLE;
      end
    endcase
  end

  // Control state and running sums.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wdcm_pkg::EN_IDLE;
      out_valid_r <= 1'b0;
      cos_sum_r   <= '0;
      sin_sum_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cos_sum_r   <= cos_sum_nxt;
      sin_sum_r   <= sin_sum_nxt;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk) begin
    x0_r        <= x0_nxt;
    y0_r        <= y0_nxt;
    z0_r        <= z0_nxt;
    x1_r        <= x1_nxt;
    y1_r        <= y1_nxt;
    z1_r        <= z1_nxt;
    flip0_r     <= flip0_nxt;
    flip1_r     <= flip1_nxt;
    step_r      <= step_nxt;
    old_valid_r <= old_valid_nxt;
    count_r     <= count_nxt;
    zero_r      <= zero_nxt;
    out_mean_r  <= out_mean_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_mean  = out_mean_r;
  assign out_count = out_count_r;

endmodule

FILE: src/wind_direction_circular_mean.sv
// Wind direction circular mean over a moving window of samples.
//
// Input channel in_ch: one binary-angle wind direction per transaction
// (65536 is a full turn at the default angle width). Result channel out_ch:
// one transaction per input, carrying the direction of the summed unit
// vectors of the filled window entries as a signed binary angle, and the
// number of entries that took part. An all-zero vector gives a zero angle.
//
// The engine takes one transaction at a time and accepts the next only when
// it has handed over the last result: one 16-step rotation pass for the new
// and evicted samples side by side, then one vectoring pass of ANGLE_BITS
// steps, capped at VEC_STEPS_MAX, in the same iterated CORDIC unit.
//
// The front end accepts a new sample as soon as the previous one is queued;
// a two-entry queue lets it run ahead of the engine. When the receiver
// stalls, the result waits in the output register and the engine holds its
// next result; samples keep entering until the queue and the front end are full.
// Reset (rst_n low, synchronous) empties the window, clears the sums and
// drops any queued or pending transaction. No clearing pass is needed.
// Depends on wdcm_pkg, the channel interfaces and the wdcm_* submodules.
`timescale 1ns / 1ps

module wind_direction_circular_mean #(
  parameter int WINDOW     = wdcm_pkg::WINDOW_DEF,
  parameter int ANGLE_BITS = wdcm_pkg::ANGLE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  wdcm_in_if.sink    in_ch,
  wdcm_out_if.source out_ch
);

  localparam int ENTRY_W = 2 * ANGLE_BITS + $clog2(WINDOW + 1) + 1;

  logic               push_valid, push_ready;
  logic [ENTRY_W-1:0] push_data;
  logic               pop_valid, pop_ready;
  logic [ENTRY_W-1:0] pop_data;

  // Window bookkeeping and input handshake.
  wdcm_front #(
    .WINDOW     (WINDOW),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_angle   (in_ch.wind_angle),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Queue between front end and engine.
  wdcm_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (wdcm_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // CORDIC engine and output register.
  wdcm_engine #(
    .WINDOW     (WINDOW),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_mean  (out_ch.mean_angle),
    .out_count (out_ch.filled_count)
  );

endmodule
